// ===== hdl/lrcbp_pkg.sv =====
// Shared types and constants for the LRC block placement lookup.
`timescale 1ns / 1ps

package lrcbp_pkg;

  localparam int unsigned W         = 16;
  localparam int unsigned CntW      = $clog2(W);
  localparam int unsigned MaxGroups = 64;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DataW     = 32;

  typedef logic [W-1:0] word_t;

  typedef enum logic [1:0] {
    REG_DATA_COUNT   = 2'd0,
    REG_GLOBAL_COUNT = 2'd1,
    REG_GROUP_COUNT  = 2'd2,
    REG_CODE_KIND    = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    CODE_NOLOC   = 3'd0,
    CODE_OPTIMAL = 3'd1,
    CODE_UNIFORM = 3'd2,
    CODE_UNI     = 3'd3,
    CODE_LOTUS   = 3'd4
  } code_e;

  typedef enum logic [1:0] {
    BK_DATA   = 2'd0,
    BK_GLOBAL = 2'd1,
    BK_LOCAL  = 2'd2
  } bk_e;

endpackage

// ===== hdl/lrc_block_placement_lookup.sv =====
// Top level of the LRC block placement lookup: registers, sequencer and shared divider.
//
// Usage: program data_count, global_parity_count, local_group_count and code_kind
// through the APB port (byte addresses 0, 4, 8, 12; pready is always high), then
// issue a lookup by raising start with lookup_id_i. The id is taken at a rising edge
// with start high and busy low. busy stays high until the result is shown.
// The result (block_kind, placement_group, local_group, has_local_group, status)
// is on the output ports for exactly one cycle, marked by done_o, and must be
// taken then; the receiver cannot stall it.
// Sequencing: a small sequencer walks the layout one group or one rack per step,
// and every division goes through one shared restoring divider, which is loaded and
// then stepped once per quotient bit. An invalid setting answers in the cycle after
// the lookup is taken; a valid lookup runs one to three divisions up front and then
// walks its layout: up to 32 groups when uniform, up to 16 groups twice when lotus.
// One lookup is in flight at a time; the next is taken the cycle after done_o.
// Reset restores k=6, r=2, z=2, code 1 and returns the sequencer to idle.
// Invalid configurations or ids give status 1 with all other fields zero.
`timescale 1ns / 1ps

module lrc_block_placement_lookup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrcbp_pkg::AddrW-1:0]   paddr,
  input  logic [lrcbp_pkg::DataW-1:0]   pwdata,
  output logic [lrcbp_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    lookup_id_i,
  output logic                          done_o,
  output logic [1:0]                    block_kind_o,
  output logic [5:0]                    placement_group_o,
  output logic [4:0]                    local_group_o,
  output logic                          has_local_group_o,
  output logic                          status_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_OUT,
    S_O0, S_O1, S_O2, S_O3, S_O4, S_O5,
    S_U0, S_U1, S_U2, S_U3, S_U4,
    S_N0, S_N1, S_N2, S_N3,
    S_T0, S_T1, S_T2, S_T3, S_T4, S_T5
  } state_e;

  localparam int unsigned W = lrcbp_pkg::W;

  state_e st_q, ret_q;

  logic [7:0] k_q;
  logic [5:0] r_q, z_q;
  logic [2:0] code_q;
  logic [7:0] id_q;

  lrcbp_pkg::word_t quo_q, rem_q, dvs_q;
  logic [lrcbp_pkg::CntW-1:0] cnt_q;

  lrcbp_pkg::word_t l_q, n1_q, base_q, ext_q, gs_q, larger_q, cap_q, g_q;
  lrcbp_pkg::word_t s_q, gn_q, o_q, pos_q, i_q, start_q, gbase_q;
  logic gl_q, pass_q;

  logic [1:0] rk_q;
  lrcbp_pkg::word_t rpg_q, rlg_q;
  logic rhas_q, rok_q;

  lrcbp_pkg::word_t kx, rx, zx, idx, krx, s_u, s_t, opt_d, lot_d, pn, dcnt, rel;
  logic gl_t, cfg_ok, good;
  logic [W:0] tmp;
  logic ge;

  always_comb begin
    kx    = lrcbp_pkg::word_t'(k_q);
    rx    = lrcbp_pkg::word_t'(r_q);
    zx    = lrcbp_pkg::word_t'(z_q);
    idx   = lrcbp_pkg::word_t'(id_q);
    krx   = kx + rx;
    rel   = idx - krx;
    s_u   = gs_q + lrcbp_pkg::word_t'(i_q >= zx - larger_q);
    s_t   = gs_q + lrcbp_pkg::word_t'(i_q >= g_q - larger_q);
    gl_t  = (i_q + rx) >= g_q;
    pn    = lrcbp_pkg::word_t'(gl_q) + lrcbp_pkg::word_t'(2);
    dcnt  = s_q - pn;
    opt_d = base_q + lrcbp_pkg::word_t'(pos_q < ext_q)
          - lrcbp_pkg::word_t'(pos_q == n1_q - lrcbp_pkg::word_t'(1));
    lot_d = base_q + lrcbp_pkg::word_t'(pos_q < ext_q) - lrcbp_pkg::word_t'(pos_q < pn);
    cfg_ok = (k_q >= 8'd1) && (k_q <= 8'd128) && (r_q >= 6'd1) && (r_q <= 6'd32)
          && (z_q >= 6'd1) && (z_q <= 6'd32);
    tmp   = {rem_q, quo_q[W-1]};
    ge    = tmp >= {1'b0, dvs_q};
  end

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    case (lrcbp_pkg::reg_e'(paddr[3:2]))
      lrcbp_pkg::REG_DATA_COUNT:   prdata = lrcbp_pkg::DataW'(k_q);
      lrcbp_pkg::REG_GLOBAL_COUNT: prdata = lrcbp_pkg::DataW'(r_q);
      lrcbp_pkg::REG_GROUP_COUNT:  prdata = lrcbp_pkg::DataW'(z_q);
      lrcbp_pkg::REG_CODE_KIND:    prdata = lrcbp_pkg::DataW'(code_q);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= 8'd6;
      r_q    <= 6'd2;
      z_q    <= 6'd2;
      code_q <= 3'd1;
    end else if (psel && penable && pwrite) begin
      case (lrcbp_pkg::reg_e'(paddr[3:2]))
        lrcbp_pkg::REG_DATA_COUNT:   k_q    <= pwdata[7:0];
        lrcbp_pkg::REG_GLOBAL_COUNT: r_q    <= pwdata[5:0];
        lrcbp_pkg::REG_GROUP_COUNT:  z_q    <= pwdata[5:0];
        lrcbp_pkg::REG_CODE_KIND:    code_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // sequencer and shared divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      ret_q <= S_IDLE;
      rok_q <= 1'b0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (start) begin
            id_q   <= lookup_id_i;
            rhas_q <= 1'b1;
            if (!cfg_ok) begin
              rok_q <= 1'b0;
              st_q  <= S_OUT;
            end else begin
              case (lrcbp_pkg::code_e'(code_q))
                lrcbp_pkg::CODE_NOLOC, lrcbp_pkg::CODE_OPTIMAL: st_q <= S_O0;
                lrcbp_pkg::CODE_UNIFORM: st_q <= S_U0;
                lrcbp_pkg::CODE_UNI:     st_q <= S_N0;
                lrcbp_pkg::CODE_LOTUS:   st_q <= S_T0;
                default: begin
                  rok_q <= 1'b0;
                  st_q  <= S_OUT;
                end
              endcase
            end
          end
        end
        S_DIV: begin
          rem_q <= ge ? W'(tmp - {1'b0, dvs_q}) : tmp[W-1:0];
          quo_q <= {quo_q[W-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == lrcbp_pkg::CntW'(W - 1)) st_q <= ret_q;
        end
        S_OUT: st_q <= S_IDLE;

        // optimal layout, global parity with or without local group
        S_O0: begin
          quo_q <= kx; rem_q <= '0; dvs_q <= zx; cnt_q <= '0;
          ret_q <= S_O1; st_q <= S_DIV;
        end
        S_O1: begin
          l_q   <= quo_q;
          quo_q <= quo_q; rem_q <= '0; dvs_q <= rx + 1'b1; cnt_q <= '0;
          ret_q <= S_O2; st_q <= S_DIV;
        end
        S_O2: begin
          n1_q  <= quo_q + 1'b1;
          quo_q <= l_q + 1'b1; rem_q <= '0; dvs_q <= quo_q + 1'b1; cnt_q <= '0;
          ret_q <= S_O3; st_q <= S_DIV;
        end
        S_O3: begin
          base_q <= quo_q;
          ext_q  <= rem_q;
          if (idx < kx) begin
            if (idx >= W'(zx * l_q)) begin
              rok_q <= 1'b0; st_q <= S_OUT;
            end else begin
              quo_q <= idx; rem_q <= '0; dvs_q <= l_q; cnt_q <= '0;
              ret_q <= S_O4; st_q <= S_DIV;
            end
          end else if (idx < krx) begin
            rk_q   <= lrcbp_pkg::BK_GLOBAL;
            rpg_q  <= W'(zx * n1_q);
            rlg_q  <= '0;
            rhas_q <= (code_q != lrcbp_pkg::CODE_NOLOC);
            rok_q  <= 1'b1; st_q <= S_OUT;
          end else if (idx < krx + zx) begin
            rk_q  <= lrcbp_pkg::BK_LOCAL;
            rpg_q <= W'(rel * n1_q) + n1_q - 1'b1;
            rlg_q <= rel;
            rok_q <= 1'b1; st_q <= S_OUT;
          end else begin
            rok_q <= 1'b0; st_q <= S_OUT;
          end
        end
        S_O4: begin
          rlg_q <= quo_q;
          o_q   <= rem_q;
          pos_q <= '0;
          st_q  <= S_O5;
        end
        S_O5: begin
          if (pos_q >= n1_q) begin
            rok_q <= 1'b0; st_q <= S_OUT;
          end else if (o_q < opt_d) begin
            rk_q  <= lrcbp_pkg::BK_DATA;
            rpg_q <= W'(rlg_q * n1_q) + pos_q;
            rok_q <= 1'b1; st_q <= S_OUT;
          end else begin
            o_q   <= o_q - opt_d;
            pos_q <= pos_q + 1'b1;
          end
        end

        // uniform layout
        S_U0: begin
          quo_q <= krx; rem_q <= '0; dvs_q <= zx; cnt_q <= '0;
          ret_q <= S_U1; st_q <= S_DIV;
        end
        S_U1: begin
          gs_q     <= quo_q + 1'b1;
          larger_q <= rem_q;
          cap_q    <= rx + 1'b1;
          i_q      <= '0;
          start_q  <= '0;
          gbase_q  <= '0;
          st_q     <= S_U2;
        end
        S_U2: begin
          if (i_q >= zx) begin
            rok_q <= 1'b0; st_q <= S_OUT;
          end else begin
            s_q   <= s_u;
            quo_q <= s_u + cap_q - 1'b1; rem_q <= '0; dvs_q <= cap_q; cnt_q <= '0;
            ret_q <= S_U3; st_q <= S_DIV;
          end
        end
        S_U3: begin
          gn_q <= quo_q;
          if (idx >= krx && rel == i_q) begin
            rk_q  <= lrcbp_pkg::BK_LOCAL;
            rpg_q <= gbase_q + quo_q - 1'b1;
            rlg_q <= i_q;
            rok_q <= 1'b1; st_q <= S_OUT;
          end else if (idx < krx && idx < start_q + s_q - 1'b1) begin
            quo_q <= idx - start_q; rem_q <= '0; dvs_q <= cap_q; cnt_q <= '0;
            ret_q <= S_U4; st_q <= S_DIV;
          end else begin
            start_q <= start_q + s_q - 1'b1;
            gbase_q <= gbase_q + quo_q;
            i_q     <= i_q + 1'b1;
            st_q    <= S_U2;
          end
        end
        S_U4: begin
          rk_q  <= (idx < kx) ? lrcbp_pkg::BK_DATA : lrcbp_pkg::BK_GLOBAL;
          rpg_q <= gbase_q + quo_q;
          rlg_q <= i_q;
          rok_q <= 1'b1; st_q <= S_OUT;
        end

        // one rack per group
        S_N0: begin
          quo_q <= kx; rem_q <= '0; dvs_q <= zx; cnt_q <= '0;
          ret_q <= S_N1; st_q <= S_DIV;
        end
        S_N1: begin
          l_q   <= quo_q;
          quo_q <= rx; rem_q <= '0; dvs_q <= zx; cnt_q <= '0;
          ret_q <= S_N2; st_q <= S_DIV;
        end
        S_N2: begin
          if (idx < kx) begin
            rk_q <= lrcbp_pkg::BK_DATA;
            if (idx >= W'(zx * l_q)) begin
              rok_q <= 1'b0; st_q <= S_OUT;
            end else begin
              quo_q <= idx; rem_q <= '0; dvs_q <= l_q; cnt_q <= '0;
              ret_q <= S_N3; st_q <= S_DIV;
            end
          end else if (idx < krx) begin
            rk_q <= lrcbp_pkg::BK_GLOBAL;
            if (idx - kx >= W'(zx * quo_q)) begin
              rok_q <= 1'b0; st_q <= S_OUT;
            end else begin
              quo_q <= idx - kx; rem_q <= '0; dvs_q <= quo_q; cnt_q <= '0;
              ret_q <= S_N3; st_q <= S_DIV;
            end
          end else if (idx < krx + zx) begin
            rk_q  <= lrcbp_pkg::BK_LOCAL;
            rpg_q <= rel;
            rlg_q <= rel;
            rok_q <= 1'b1; st_q <= S_OUT;
          end else begin
            rok_q <= 1'b0; st_q <= S_OUT;
          end
        end
        S_N3: begin
          rpg_q <= quo_q;
          rlg_q <= quo_q;
          rok_q <= 1'b1; st_q <= S_OUT;
        end

        // lotus layout: pass 0 checks rack counts, pass 1 locates the id
        S_T0: begin
          if (z_q < 6'd2 || rx > (zx >> 1)) begin
            rok_q <= 1'b0; st_q <= S_OUT;
          end else begin
            g_q   <= zx >> 1;
            quo_q <= krx; rem_q <= '0; dvs_q <= zx >> 1; cnt_q <= '0;
            ret_q <= S_T1; st_q <= S_DIV;
          end
        end
        S_T1: begin
          gs_q     <= quo_q + lrcbp_pkg::word_t'(2);
          larger_q <= rem_q;
          cap_q    <= rx + lrcbp_pkg::word_t'(2);
          i_q      <= '0;
          pass_q   <= 1'b0;
          start_q  <= '0;
          gbase_q  <= '0;
          st_q     <= S_T2;
        end
        S_T2: begin
          if (i_q >= g_q) begin
            if (!pass_q) begin
              pass_q <= 1'b1;
              i_q    <= '0;
            end else begin
              rok_q <= 1'b0; st_q <= S_OUT;
            end
          end else begin
            s_q   <= s_t;
            gl_q  <= gl_t;
            quo_q <= s_t + cap_q - 1'b1; rem_q <= '0; dvs_q <= cap_q; cnt_q <= '0;
            ret_q <= S_T3; st_q <= S_DIV;
          end
        end
        S_T3: begin
          gn_q <= quo_q;
          if (!pass_q) begin
            if (quo_q < pn) begin
              rok_q <= 1'b0; st_q <= S_OUT;
            end else begin
              i_q  <= i_q + 1'b1;
              st_q <= S_T2;
            end
          end else if (idx < kx && idx < start_q + dcnt) begin
            o_q   <= idx - start_q;
            quo_q <= s_q; rem_q <= '0; dvs_q <= quo_q; cnt_q <= '0;
            ret_q <= S_T4; st_q <= S_DIV;
          end else if (idx >= kx && idx < krx && gl_q && (idx - kx + g_q == i_q + rx)) begin
            rk_q  <= lrcbp_pkg::BK_GLOBAL;
            rpg_q <= gbase_q;
            rlg_q <= i_q;
            rok_q <= 1'b1; st_q <= S_OUT;
          end else if (idx >= krx && idx < krx + (g_q << 1) && (rel >> 1) == i_q) begin
            rk_q  <= lrcbp_pkg::BK_LOCAL;
            rpg_q <= gbase_q + lrcbp_pkg::word_t'(gl_q) + lrcbp_pkg::word_t'(rel[0]);
            rlg_q <= i_q;
            rok_q <= 1'b1; st_q <= S_OUT;
          end else begin
            start_q <= start_q + dcnt;
            gbase_q <= gbase_q + quo_q;
            i_q     <= i_q + 1'b1;
            st_q    <= S_T2;
          end
        end
        S_T4: begin
          base_q <= quo_q;
          ext_q  <= rem_q;
          pos_q  <= '0;
          st_q   <= S_T5;
        end
        S_T5: begin
          if (pos_q >= gn_q) begin
            rok_q <= 1'b0; st_q <= S_OUT;
          end else if (o_q < lot_d) begin
            rk_q  <= lrcbp_pkg::BK_DATA;
            rpg_q <= gbase_q + pos_q;
            rlg_q <= i_q;
            rok_q <= 1'b1; st_q <= S_OUT;
          end else begin
            o_q   <= o_q - lot_d;
            pos_q <= pos_q + 1'b1;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign good              = rok_q && (rpg_q < lrcbp_pkg::word_t'(lrcbp_pkg::MaxGroups));
  assign busy              = (st_q != S_IDLE);
  assign done_o            = (st_q == S_OUT);
  assign block_kind_o      = good ? rk_q : 2'd0;
  assign placement_group_o = good ? rpg_q[5:0] : 6'd0;
  assign local_group_o     = good ? rlg_q[4:0] : 5'd0;
  assign has_local_group_o = good && rhas_q;
  assign status_o          = !good;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted lookup did not raise busy");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> block_kind_o == 2'd0 && placement_group_o == 6'd0
      && local_group_o == 5'd0 && !has_local_group_o)
    else $error("error result carries nonzero fields");

  a_kind_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !status_o |-> block_kind_o != 2'd3) else $error("bad block kind");

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the LRC block placement lookup: directed table, random lookups, predictor check.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] pg;
    logic [4:0] lg;
    logic       has;
    logic       status;
  } placement_t;

  typedef struct {
    logic [7:0] id;
    bit         known;
    placement_t res;
  } lookup_row_t;

  localparam int unsigned CycleLimit = 4_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [lrcbp_pkg::AddrW-1:0] paddr;
  logic [lrcbp_pkg::DataW-1:0] pwdata;
  logic [lrcbp_pkg::DataW-1:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [7:0]  lookup_id_i;
  logic        done_o;
  logic [1:0]  block_kind_o;
  logic [5:0]  placement_group_o;
  logic [4:0]  local_group_o;
  logic        has_local_group_o;
  logic        status_o;

  int unsigned cfg_k, cfg_r, cfg_z;
  lrcbp_pkg::code_e cfg_code;
  placement_t  pending_q[$];
  int unsigned err_cnt;
  int unsigned lookup_cnt;
  int unsigned result_cnt;
  int unsigned cycle_cnt;
  int unsigned gap_pct;
  int unsigned error_seen;

  lrc_block_placement_lookup dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .lookup_id_i(lookup_id_i),
    .done_o(done_o), .block_kind_o(block_kind_o),
    .placement_group_o(placement_group_o), .local_group_o(local_group_o),
    .has_local_group_o(has_local_group_o), .status_o(status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic placement_t fail_result();
    placement_t p;
    p = '0;
    p.status = 1'b1;
    return p;
  endfunction

  function automatic placement_t ok_result(int unsigned kind, int unsigned pg,
                                           int unsigned lg, int unsigned has);
    placement_t p;
    if (pg >= lrcbp_pkg::MaxGroups) return fail_result();
    p.kind = kind[1:0];
    p.pg = pg[5:0];
    p.lg = lg[4:0];
    p.has = has[0];
    p.status = 1'b0;
    return p;
  endfunction

  function automatic placement_t place_optimal(int unsigned id, int unsigned k,
                                               int unsigned r, int unsigned z, bit noloc);
    int unsigned grp_len, racks, base, extra, off, rack, slots;
    grp_len = k / z;
    racks = grp_len / (r + 1) + 1;
    base = (grp_len + 1) / racks;
    extra = (grp_len + 1) % racks;
    if (id < k) begin
      if (id >= z * grp_len) return fail_result();
      off = id % grp_len;
      for (rack = 0; rack < racks; rack++) begin
        slots = base + (rack < extra) - (rack == racks - 1);
        if (off < slots) break;
        off -= slots;
      end
      if (rack >= racks) return fail_result();
      return ok_result(lrcbp_pkg::BK_DATA, (id / grp_len) * racks + rack, id / grp_len, 1);
    end
    if (id < k + r) return ok_result(lrcbp_pkg::BK_GLOBAL, z * racks, 0, noloc ? 0 : 1);
    if (id < k + r + z)
      return ok_result(lrcbp_pkg::BK_LOCAL, (id - k - r) * racks + racks - 1, id - k - r, 1);
    return fail_result();
  endfunction

  function automatic placement_t place_uniform(int unsigned id, int unsigned k,
                                               int unsigned r, int unsigned z);
    int unsigned gsize, larger, cap, first, rbase, s, nr;
    gsize = (k + r) / z + 1;
    larger = (k + r) % z;
    cap = r + 1;
    first = 0;
    rbase = 0;
    for (int unsigned i = 0; i < z; i++) begin
      s = gsize + (i >= z - larger);
      nr = (s + cap - 1) / cap;
      if (id >= k + r) begin
        if (id - k - r == i) return ok_result(lrcbp_pkg::BK_LOCAL, rbase + nr - 1, i, 1);
      end else if (id < first + s - 1) begin
        return ok_result(id < k ? lrcbp_pkg::BK_DATA : lrcbp_pkg::BK_GLOBAL,
                         rbase + (id - first) / cap, i, 1);
      end
      first += s - 1;
      rbase += nr;
    end
    return fail_result();
  endfunction

  function automatic placement_t place_uni(int unsigned id, int unsigned k,
                                           int unsigned r, int unsigned z);
    int unsigned dper, gper;
    dper = k / z;
    gper = r / z;
    if (id < k) begin
      if (id >= z * dper) return fail_result();
      return ok_result(lrcbp_pkg::BK_DATA, id / dper, id / dper, 1);
    end
    if (id < k + r) begin
      if (id - k >= z * gper) return fail_result();
      return ok_result(lrcbp_pkg::BK_GLOBAL, (id - k) / gper, (id - k) / gper, 1);
    end
    if (id < k + r + z) return ok_result(lrcbp_pkg::BK_LOCAL, id - k - r, id - k - r, 1);
    return fail_result();
  endfunction

  function automatic placement_t place_lotus(int unsigned id, int unsigned k,
                                             int unsigned r, int unsigned z);
    int unsigned ng, gsize, larger, cap, first, rbase, s, hasg, nr, npar, ndata;
    int unsigned rsz, rext, off, rack, slots;
    if (z < 2) return fail_result();
    ng = z / 2;
    if (r > ng) return fail_result();
    gsize = (k + r) / ng + 2;
    larger = (k + r) % ng;
    cap = r + 2;
    for (int unsigned i = 0; i < ng; i++) begin
      s = gsize + (i >= ng - larger);
      hasg = (i + r >= ng);
      if ((s + cap - 1) / cap < hasg + 2) return fail_result();
    end
    first = 0;
    rbase = 0;
    for (int unsigned i = 0; i < ng; i++) begin
      s = gsize + (i >= ng - larger);
      hasg = (i + r >= ng);
      nr = (s + cap - 1) / cap;
      npar = hasg + 2;
      ndata = s - npar;
      rsz = s / nr;
      rext = s % nr;
      if (id < k) begin
        if (id < first + ndata) begin
          off = id - first;
          for (rack = 0; rack < nr; rack++) begin
            slots = rsz + (rack < rext) - (rack < npar);
            if (off < slots) break;
            off -= slots;
          end
          if (rack >= nr) return fail_result();
          return ok_result(lrcbp_pkg::BK_DATA, rbase + rack, i, 1);
        end
      end else if (id < k + r) begin
        if (hasg && id - k + ng == i + r) return ok_result(lrcbp_pkg::BK_GLOBAL, rbase, i, 1);
      end else if (id < k + r + 2 * ng) begin
        if ((id - k - r) / 2 == i)
          return ok_result(lrcbp_pkg::BK_LOCAL, rbase + hasg + (id - k - r) % 2, i, 1);
      end
      first += ndata;
      rbase += nr;
    end
    return fail_result();
  endfunction

  function automatic placement_t predict_placement(logic [7:0] id);
    if (cfg_k < 1 || cfg_k > 128 || cfg_r < 1 || cfg_r > 32 || cfg_z < 1 || cfg_z > 32)
      return fail_result();
    case (cfg_code)
      lrcbp_pkg::CODE_NOLOC:   return place_optimal(id, cfg_k, cfg_r, cfg_z, 1'b1);
      lrcbp_pkg::CODE_OPTIMAL: return place_optimal(id, cfg_k, cfg_r, cfg_z, 1'b0);
      lrcbp_pkg::CODE_UNIFORM: return place_uniform(id, cfg_k, cfg_r, cfg_z);
      lrcbp_pkg::CODE_UNI:     return place_uni(id, cfg_k, cfg_r, cfg_z);
      lrcbp_pkg::CODE_LOTUS:   return place_lotus(id, cfg_k, cfg_r, cfg_z);
      default:                 return fail_result();
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, result_cnt);
    err_cnt++;
  endtask

  // result monitor
  always @(posedge clk_i) begin
    placement_t want;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        want = pending_q.pop_front();
        if (block_kind_o !== want.kind) report_mismatch("block_kind", block_kind_o, want.kind);
        if (placement_group_o !== want.pg)
          report_mismatch("placement_group", placement_group_o, want.pg);
        if (local_group_o !== want.lg) report_mismatch("local_group", local_group_o, want.lg);
        if (has_local_group_o !== want.has)
          report_mismatch("has_local_group", has_local_group_o, want.has);
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (want.status) error_seen++;
      end
      result_cnt++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(lrcbp_pkg::reg_e idx, int unsigned value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= lrcbp_pkg::AddrW'(4 * idx);
    pwdata <= lrcbp_pkg::DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      lrcbp_pkg::REG_DATA_COUNT:   cfg_k = value & 8'hFF;
      lrcbp_pkg::REG_GLOBAL_COUNT: cfg_r = value & 6'h3F;
      lrcbp_pkg::REG_GROUP_COUNT:  cfg_z = value & 6'h3F;
      lrcbp_pkg::REG_CODE_KIND:    cfg_code = lrcbp_pkg::code_e'(value & 3'h7);
      default: ;
    endcase
  endtask

  task automatic set_layout(int unsigned k, int unsigned r, int unsigned z, int unsigned code);
    write_reg(lrcbp_pkg::REG_DATA_COUNT, k);
    write_reg(lrcbp_pkg::REG_GLOBAL_COUNT, r);
    write_reg(lrcbp_pkg::REG_GROUP_COUNT, z);
    write_reg(lrcbp_pkg::REG_CODE_KIND, code);
  endtask

  // Issues one lookup: an optional random gap first, then start with the id; start is dropped after each lookup.
  task automatic issue_lookup(logic [7:0] id, bit known, placement_t res);
    placement_t want;
    while (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      @(posedge clk_i);
      start <= 1'b0;
    end
    want = predict_placement(id);
    if (known && want !== res) report_mismatch("table row vs predictor", want, res);
    @(posedge clk_i);
    start <= 1'b1;
    lookup_id_i <= id;
    do @(posedge clk_i); while (busy);
    pending_q.insert(pending_q.size(), want);
    lookup_cnt++;
    start <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // id chosen mostly within the stripe, sometimes beyond it
  function automatic logic [7:0] pick_id();
    int unsigned span;
    span = cfg_k + cfg_r + cfg_z + 2;
    if (span > 255) span = 255;
    if ($urandom_range(9, 0) == 0) return 8'($urandom_range(255, 0));
    return 8'($urandom_range(span, 0));
  endfunction

  task automatic random_layout();
    int unsigned sel;
    sel = $urandom_range(9, 0);
    case (sel)
      0: set_layout(128, 32, 32, $urandom_range(4, 0));
      1: set_layout(1, 1, 1, $urandom_range(4, 0));
      2: set_layout($urandom_range(255, 0), $urandom_range(63, 0),
                    $urandom_range(63, 0), $urandom_range(7, 0));
      3: set_layout($urandom_range(40, 2), $urandom_range(4, 1), $urandom_range(12, 2),
                    lrcbp_pkg::CODE_LOTUS);
      default: set_layout($urandom_range(48, 1), $urandom_range(6, 1),
                          $urandom_range(8, 1), $urandom_range(4, 0));
    endcase
  endtask

  lookup_row_t dir_rows[$];

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    start = 1'b0; lookup_id_i = '0;
    err_cnt = 0; lookup_cnt = 0; result_cnt = 0; cycle_cnt = 0; gap_pct = 0;
    error_seen = 0;
    cfg_k = 6; cfg_r = 2; cfg_z = 2; cfg_code = lrcbp_pkg::CODE_OPTIMAL;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset layout k=6 r=2 z=2 optimal: L=3, 2 racks per group, global rack 4
    dir_rows = '{
      '{8'd0,   1, '{2'd0, 6'd0, 5'd0, 1'b1, 1'b0}},
      '{8'd5,   1, '{2'd0, 6'd3, 5'd1, 1'b1, 1'b0}},
      '{8'd6,   1, '{2'd1, 6'd4, 5'd0, 1'b1, 1'b0}},
      '{8'd7,   1, '{2'd1, 6'd4, 5'd0, 1'b1, 1'b0}},
      '{8'd8,   1, '{2'd2, 6'd1, 5'd0, 1'b1, 1'b0}},
      '{8'd9,   1, '{2'd2, 6'd3, 5'd1, 1'b1, 1'b0}},
      '{8'd10,  1, '{2'd0, 6'd0, 5'd0, 1'b0, 1'b1}},
      '{8'd255, 1, '{2'd0, 6'd0, 5'd0, 1'b0, 1'b1}},
      '{8'd1,   0, '0},
      '{8'd3,   0, '0}
    };
    foreach (dir_rows[i]) issue_lookup(dir_rows[i].id, dir_rows[i].known, dir_rows[i].res);
    drain();
    // every scheme at a small layout, plus invalid setups
    for (int unsigned c = 0; c <= 5; c++) begin
      set_layout(c == lrcbp_pkg::CODE_LOTUS ? 10 : 7, 2,
                 c == lrcbp_pkg::CODE_LOTUS ? 6 : 3, c);
      for (int unsigned id = 0; id < 3; id++) issue_lookup(8'(id * 5), 0, '0);
      drain();
    end
    set_layout(0, 2, 2, lrcbp_pkg::CODE_OPTIMAL);
    issue_lookup(8'd0, 1, fail_result());
    drain();
    set_layout(128, 32, 32, lrcbp_pkg::CODE_UNIFORM);
    issue_lookup(8'd200, 0, '0);
    issue_lookup(8'd191, 0, '0);
    drain();

    for (int unsigned phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 36 : (phase == 1) ? 60 : 0;
      for (int unsigned n = 0; n < 300; n++) begin
        if (n % 30 == 0) begin
          drain();
          random_layout();
        end
        issue_lookup(pick_id(), 0, '0);
      end
      drain();
    end

    $display("covered %0d lookups over all layout schemes, %0d of them flagged errors",
             lookup_cnt, error_seen);
    $display("register writes spanned limits and invalid settings; gaps at 36%%, 60%%, 0%%");
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
